>>> design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, reset masks the check.
`define ASSERT_SAME(lbl, clk, rstn, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |-> (cons)) \
    else $error("same-cycle assertion failed");
// Next-cycle implication, reset masks the check.
`define ASSERT_NEXT(lbl, clk, rstn, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |=> (cons)) \
    else $error("next-cycle assertion failed");
`endif

>>> design/mtc_pkg.sv
// Types, codes and helper functions of the MIDI time code engine.
package mtc_pkg;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_RESET = 3'd3,
    OP_LOAD  = 3'd4,
    OP_RXQF  = 3'd5,
    OP_RXSX  = 3'd6
  } op_e;

  localparam logic [1:0] SRC_INT = 2'd1;
  localparam logic [1:0] SRC_EXT = 2'd2;

  localparam logic [2:0] CFG_SRC  = 3'd0;
  localparam logic [2:0] CFG_QFE  = 3'd1;
  localparam logic [2:0] CFG_FFE  = 3'd2;
  localparam logic [2:0] CFG_CAB  = 3'd3;
  localparam logic [2:0] CFG_RATE = 3'd4;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_QF     = 2'd1;
  localparam logic [1:0] KIND_FULL   = 2'd2;

  localparam logic [7:0] QF_STATUS  = 8'hF1;
  localparam logic [3:0] QF_CODE    = 4'h2;
  localparam logic [7:0] SX_START   = 8'hF0;
  localparam logic [7:0] SX_RT      = 8'h7F;
  localparam logic [7:0] SX_ONE     = 8'h01;
  localparam logic [7:0] SX_END     = 8'hF7;
  localparam int unsigned FULL_LEN  = 10;
  localparam int unsigned QBUF_LEN  = 10;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [4:0] frames;
    logic [1:0] rate;
  } tc_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic emit_adv;
  } dp_cmd_t;

  typedef struct packed {
    logic tick_go;
    logic more;
    logic emit_last;
  } dp_stat_t;

  function automatic logic [4:0] last_frame(input logic [1:0] rate);
    logic [4:0] r;
    unique case (rate)
      2'd0: r = 5'd23;
      2'd1: r = 5'd24;
      default: r = 5'd29;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] period_us(input logic [1:0] rate);
    logic [16:0] r;
    unique case (rate)
      2'd0: r = 17'(1000000000 / (24000 * 4));
      2'd1: r = 17'(1000000000 / (25000 * 4));
      2'd2: r = 17'(1000000000 / (29970 * 4));
      default: r = 17'(1000000000 / (30000 * 4));
    endcase
    return r;
  endfunction

  function automatic tc_t adv_frame(input tc_t t);
    tc_t r;
    r = t;
    if (t.frames + 5'd1 > last_frame(t.rate)) begin
      r.frames = '0;
      if (t.seconds + 6'd1 >= 6'd60) begin
        r.seconds = '0;
        if (t.minutes + 6'd1 >= 6'd60) begin
          r.minutes = '0;
          r.hours = (t.hours + 5'd1 >= 5'd24) ? 5'd0 : t.hours + 5'd1;
        end else begin
          r.minutes = t.minutes + 6'd1;
        end
      end else begin
        r.seconds = t.seconds + 6'd1;
      end
    end else begin
      r.frames = t.frames + 5'd1;
    end
    return r;
  endfunction

endpackage

>>> design/mtc_ctrl.sv
// Sequencing state machine: accept, quarter-frame loop, result delivery.
module mtc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output mtc_pkg::dp_cmd_t  cmd_o,
  input  mtc_pkg::dp_stat_t stat_i
);
  import mtc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = (state_q == ST_EMIT);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.accept = 1'b1;
          state_d = stat_i.tick_go ? ST_EXEC : ST_EMIT;
        end
      end
      ST_EXEC: begin
        if (stat_i.more) cmd_o.step = 1'b1;
        else state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (m_tready_i) begin
          cmd_o.emit_adv = 1'b1;
          if (stat_i.emit_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end
endmodule

>>> design/mtc_dpath.sv
// Time code state, receivers, quarter-frame buffer and result formatting.
module mtc_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic [2:0]        op_i,
  input  logic [15:0]       elapsed_us_i,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  input  logic [4:0]        set_hours_i,
  input  logic [5:0]        set_minutes_i,
  input  logic [5:0]        set_seconds_i,
  input  logic [4:0]        set_frames_i,
  input  mtc_pkg::dp_cmd_t  cmd_i,
  output mtc_pkg::dp_stat_t stat_o,
  output logic [1:0]        kind_o,
  output logic [7:0]        header_o,
  output logic [7:0]        status_o,
  output logic [7:0]        byte_o,
  output logic              last_o,
  output mtc_pkg::tc_t      tc_o,
  output logic              synced_o,
  output logic [2:0]        piece_o
);
  import mtc_pkg::*;

  logic [1:0]  src_q;
  logic        qfe_q, ffe_q;
  logic [3:0]  cable_q;
  logic [1:0]  rate_code_q;
  tc_t         tc_q, tc_d;
  logic [16:0] acc_q, acc_d;
  logic [2:0]  piece_q, piece_d;
  logic        run_q, run_d;
  logic [3:0]  nib_q [8];
  logic [7:0]  mask_q, mask_d;
  logic        sync_q, sync_d;
  logic [3:0]  pos_q, pos_d;
  logic        hok_q, hok_d;
  logic [7:0]  sxf_q [4];
  logic [7:0]  qbuf_q [QBUF_LEN];
  logic [3:0]  nq_q, nq_d;
  logic [1:0]  mode_q, mode_d;
  logic [3:0]  eidx_q;
  logic [3:0]  total;
  logic [3:0]  nib_n [8];
  logic [2:0]  qp;
  logic [7:0]  qdata;
  logic [7:0]  full_byte;
  tc_t         cand;
  logic        cand_ok;
  logic        sx_mis;

  assign stat_o.tick_go = (op_i == OP_TICK) && run_q && (src_q == SRC_INT);
  assign stat_o.more    = (acc_q >= period_us(rate_code_q));

  assign qp = in_byte_i[6:4];
  always_comb begin
    for (int i = 0; i < 8; i++) nib_n[i] = (qp == 3'(i)) ? in_byte_i[3:0] : nib_q[i];
  end

  // Quarter-frame data nibble of the current piece.
  always_comb begin
    logic [3:0] d;
    unique case (piece_q)
      3'd0: d = tc_q.frames[3:0];
      3'd1: d = {3'b0, tc_q.frames[4]};
      3'd2: d = tc_q.seconds[3:0];
      3'd3: d = {2'b0, tc_q.seconds[5:4]};
      3'd4: d = tc_q.minutes[3:0];
      3'd5: d = {2'b0, tc_q.minutes[5:4]};
      3'd6: d = tc_q.hours[3:0];
      default: d = {1'b0, tc_q.rate, tc_q.hours[4]};
    endcase
    qdata = {1'b0, piece_q, d};
  end

  assign sx_mis = (pos_q == 4'd0 && in_byte_i != SX_START) ||
                  ((pos_q == 4'd1 || pos_q == 4'd2) && in_byte_i != SX_RT) ||
                  ((pos_q == 4'd3 || pos_q == 4'd4) && in_byte_i != SX_ONE) ||
                  (pos_q == 4'd9 && in_byte_i != SX_END);

  // Candidate time code from the receivers.
  always_comb begin
    if (op_i == OP_RXQF) begin
      cand.hours   = {nib_n[7][0], nib_n[6]};
      cand.minutes = {nib_n[5][1:0], nib_n[4]};
      cand.seconds = {nib_n[3][1:0], nib_n[2]};
      cand.frames  = {nib_n[1][0], nib_n[0]};
      cand.rate    = nib_n[7][2:1];
    end else begin
      cand.hours   = sxf_q[0][4:0];
      cand.minutes = sxf_q[1][5:0];
      cand.seconds = sxf_q[2][5:0];
      cand.frames  = sxf_q[3][4:0];
      cand.rate    = sxf_q[0][6:5];
    end
    // Dropped quarter-frame nibble bits fail the check, except bit 3 of piece 7.
    cand_ok = (cand.hours < 5'd24) && (cand.minutes < 6'd60) &&
              (cand.seconds < 6'd60) && (cand.frames <= last_frame(cand.rate)) &&
              (op_i != OP_RXQF || (nib_n[5][3:2] == 2'b00 && nib_n[3][3:2] == 2'b00 &&
                                   nib_n[1][3:1] == 3'b000));
  end

  always_comb begin
    tc_d = tc_q; acc_d = acc_q; piece_d = piece_q; run_d = run_q;
    mask_d = mask_q; sync_d = sync_q; pos_d = pos_q; hok_d = hok_q;
    nq_d = nq_q; mode_d = mode_q;
    if (cfg_we_i && cfg_index_i == CFG_RATE) tc_d.rate = cfg_data_i[1:0];
    if (cmd_i.accept) begin
      nq_d = '0;
      mode_d = KIND_STATUS;
      unique case (op_i)
        OP_TICK: if (stat_o.tick_go) begin
          acc_d = acc_q + 17'(elapsed_us_i);
          mode_d = KIND_QF;
        end
        OP_START: if (src_q == SRC_INT) begin
          run_d = 1'b1;
          acc_d = '0;
          if (ffe_q) mode_d = KIND_FULL;
        end
        OP_STOP: begin
          run_d = 1'b0;
          if (ffe_q) mode_d = KIND_FULL;
        end
        OP_RESET: begin
          tc_d = '{hours: '0, minutes: '0, seconds: '0, frames: '0, rate: rate_code_q};
          piece_d = '0;
          acc_d = '0;
        end
        OP_LOAD: begin
          if (set_hours_i < 5'd24 && set_minutes_i < 6'd60 && set_seconds_i < 6'd60 &&
              set_frames_i <= last_frame(rate_code_q))
            tc_d = '{hours: set_hours_i, minutes: set_minutes_i,
                     seconds: set_seconds_i, frames: set_frames_i, rate: rate_code_q};
        end
        OP_RXQF: if (src_q == SRC_EXT) begin
          mask_d = mask_q | (8'd1 << qp);
          if (mask_d == 8'hFF) begin
            if (cand_ok) begin tc_d = cand; sync_d = 1'b1; end
            mask_d = '0;
          end
        end
        OP_RXSX: if (src_q == SRC_EXT) begin
          hok_d = hok_q & ~sx_mis;
          if (pos_q != 4'd15) pos_d = pos_q + 4'd1;
          if (in_last_i) begin
            if (pos_q >= 4'd9 && hok_d && cand_ok) begin tc_d = cand; sync_d = 1'b1; end
            pos_d = '0;
            hok_d = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.step) begin
      acc_d = acc_q - period_us(rate_code_q);
      if (qfe_q) begin
        if (nq_q != 4'(QBUF_LEN)) nq_d = nq_q + 4'd1;
        piece_d = piece_q + 3'd1;
        if (piece_d == 3'd0) tc_d = adv_frame(adv_frame(tc_q));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= '0; qfe_q <= 1'b0; ffe_q <= 1'b0; cable_q <= '0; rate_code_q <= 2'd3;
      tc_q <= '{hours: '0, minutes: '0, seconds: '0, frames: '0, rate: 2'd3};
      acc_q <= '0; piece_q <= '0; run_q <= 1'b0; mask_q <= '0; sync_q <= 1'b0;
      pos_q <= '0; hok_q <= 1'b1; nq_q <= '0; mode_q <= KIND_STATUS; eidx_q <= '0;
      for (int i = 0; i < 8; i++) nib_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SRC:  src_q <= cfg_data_i[1:0];
          CFG_QFE:  qfe_q <= cfg_data_i[0];
          CFG_FFE:  ffe_q <= cfg_data_i[0];
          CFG_CAB:  cable_q <= cfg_data_i[3:0];
          CFG_RATE: rate_code_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      tc_q <= tc_d; acc_q <= acc_d; piece_q <= piece_d; run_q <= run_d;
      mask_q <= mask_d; sync_q <= sync_d; pos_q <= pos_d; hok_q <= hok_d;
      nq_q <= nq_d; mode_q <= mode_d;
      if (cmd_i.accept && op_i == OP_RXQF && src_q == SRC_EXT) nib_q[qp] <= in_byte_i[3:0];
      if (cmd_i.accept) eidx_q <= '0;
      else if (cmd_i.emit_adv) eidx_q <= eidx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && op_i == OP_RXSX && src_q == SRC_EXT && pos_q >= 4'd5 && pos_q < 4'd9)
      sxf_q[pos_q[1:0] - 2'd1] <= in_byte_i;
    if (cmd_i.step && qfe_q && nq_q != 4'(QBUF_LEN)) qbuf_q[nq_q] <= qdata;
  end

  always_comb begin
    unique case (eidx_q)
      4'd0: full_byte = SX_START;
      4'd1, 4'd2: full_byte = SX_RT;
      4'd3, 4'd4: full_byte = SX_ONE;
      4'd5: full_byte = {1'b0, tc_q.rate, tc_q.hours};
      4'd6: full_byte = {2'b0, tc_q.minutes};
      4'd7: full_byte = {2'b0, tc_q.seconds};
      4'd8: full_byte = {3'b0, tc_q.frames};
      default: full_byte = SX_END;
    endcase
  end

  always_comb begin
    kind_o = KIND_STATUS; header_o = '0; status_o = '0; byte_o = '0; total = 4'd1;
    if (mode_q == KIND_FULL) begin
      kind_o = KIND_FULL; byte_o = full_byte; total = 4'(FULL_LEN);
    end else if (mode_q == KIND_QF && nq_q != 4'd0) begin
      kind_o = KIND_QF; header_o = {cable_q, QF_CODE}; status_o = QF_STATUS;
      byte_o = qbuf_q[eidx_q]; total = nq_q;
    end
  end

  assign last_o = (eidx_q == total - 4'd1);
  assign stat_o.emit_last = last_o;
  assign tc_o = tc_q;
  assign synced_o = sync_q;
  assign piece_o = piece_q;
endmodule

>>> design/midi_timecode_engine_core.sv
// Top level of the MIDI time code engine: handshakes, controller and datapath.
// A non-tick beat is accepted while idle and its first result shows in the cycle after.
// A running tick from the internal source first steps through each elapsed quarter-frame period (0 to 9).
// Results leave one per cycle while the sink is ready: 1 status beat, up to 9 quarter frames, or 10 SysEx bytes.
// A new beat is taken only after every result of the last one has left.
// Reset (rst_ni low, asynchronous) clears all control state; time code rate starts at 30 fps.
module midi_timecode_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // elapsed_us[15:0] in_byte[23:16] set_hours[28:24] set_minutes[34:29]
  // set_seconds[40:35] set_frames[45:41], zero above
  input  logic [47:0] s_tdata_i,
  // op[2:0]
  input  logic [2:0]  s_tuser_i,
  input  logic        s_tlast_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // packet_header[7:0] out_status[15:8] out_byte[23:16] cur_hours[28:24]
  // cur_minutes[34:29] cur_seconds[40:35] cur_frames[45:41] cur_rate[47:46]
  // synced[48] piece_index[51:49], zero above
  output logic [55:0] m_tdata_o,
  // kind[1:0]
  output logic [1:0]  m_tuser_o,
  output logic        m_tlast_o
);
  import mtc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  tc_t      tc;
  logic [7:0] hdr, sts, byt;
  logic       synced;
  logic [2:0] piece;

  // The configuration channel is always ready; writes must only come while idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  // The controller takes one beat at a time and holds the input closed
  // until every result of that beat has been delivered.
  mtc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  // The datapath holds all state; results are read out of registers, so the
  // output beat stays stable while the sink stalls.
  mtc_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .op_i          (s_tuser_i),
    .elapsed_us_i  (s_tdata_i[15:0]),
    .in_byte_i     (s_tdata_i[23:16]),
    .in_last_i     (s_tlast_i),
    .set_hours_i   (s_tdata_i[28:24]),
    .set_minutes_i (s_tdata_i[34:29]),
    .set_seconds_i (s_tdata_i[40:35]),
    .set_frames_i  (s_tdata_i[45:41]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .kind_o        (m_tuser_o),
    .header_o      (hdr),
    .status_o      (sts),
    .byte_o        (byt),
    .last_o        (m_tlast_o),
    .tc_o          (tc),
    .synced_o      (synced),
    .piece_o       (piece)
  );

  assign m_tdata_o = {4'b0, piece, synced, tc.rate, tc.frames, tc.seconds,
                      tc.minutes, tc.hours, byt, sts, hdr};
endmodule

>>> design/mtc_checker.sv
// Port-level checker for the MIDI time code engine, bound to the top level.
`include "assert_macros.svh"
module mtc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tready_o,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [55:0] m_tdata_o,
  input logic [1:0]  m_tuser_o,
  input logic        m_tlast_o
);
  import mtc_pkg::*;

  `ASSERT_SAME(a_one_side, clk_i, rst_ni, 1'b1, !(s_tready_o && m_tvalid_o))
  `ASSERT_SAME(a_qf_header, clk_i, rst_ni, m_tvalid_o && m_tuser_o == KIND_QF, m_tdata_o[3:0] == QF_CODE && m_tdata_o[15:8] == QF_STATUS)
  `ASSERT_SAME(a_status_alone, clk_i, rst_ni, m_tvalid_o && m_tuser_o == KIND_STATUS, m_tlast_o)
  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, m_tvalid_o && !m_tready_i, m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o))
endmodule

bind midi_timecode_engine_core mtc_checker u_mtc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o),
  .m_tlast_o  (m_tlast_o)
);
